FILE: design/pfa_pkg.sv
// Package for the partition fit allocator.
// Holds the command, status, policy and register index codes and the control
// struct passed to the fit unit. No dependencies.
package pfa_pkg;

    localparam int OUT_IDX_W = 6;
    localparam int CFG_DATA_W = 7;

    localparam logic [1:0] CMD_LOAD = 2'd0;
    localparam logic [1:0] CMD_ALLOC = 2'd1;
    localparam logic [1:0] CMD_RESTORE = 2'd2;

    localparam logic [1:0] ST_LOADED = 2'd0;
    localparam logic [1:0] ST_ALLOCATED = 2'd1;
    localparam logic [1:0] ST_NO_SPACE = 2'd2;
    localparam logic [1:0] ST_RESTORED = 2'd3;

    localparam logic [1:0] FIT_FIRST = 2'd0;
    localparam logic [1:0] FIT_BEST = 2'd1;
    localparam logic [1:0] FIT_WORST = 2'd2;

    localparam logic REG_FIT_MODE = 1'b0;
    localparam logic REG_BLOCK_COUNT = 1'b1;

    localparam logic [6:0] BLOCK_COUNT_RESET = 7'd64;

    typedef struct packed {
        logic       clear;
        logic       step;
        logic [1:0] mode;
    } pfa_fit_ctrl_t;

endpackage

FILE: design/pfa_mem.sv
// Single-port-write, single-port-read memory with a registered read.
// Used for the original and the remaining size tables. No dependencies.
module pfa_mem #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 16,
    parameter int AW = 6
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: design/pfa_fit_unit.sv
// Shared compare unit of the partition fit allocator: one subtract and one
// magnitude compare per beat, tracking the best candidate so far.
// Depends on pfa_pkg.
module pfa_fit_unit
    import pfa_pkg::*;
#(
    parameter int SIZE_BITS = 16,
    parameter int IDX_W = 6
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  pfa_fit_ctrl_t        ctrl,
    input  logic [SIZE_BITS-1:0] size_in,
    input  logic [SIZE_BITS-1:0] req,
    input  logic [IDX_W-1:0]     idx_in,
    output logic                 found,
    output logic [IDX_W-1:0]     pick,
    output logic [SIZE_BITS-1:0] pick_left,
    output logic [SIZE_BITS-1:0] pick_before
);

    logic                 found_reg;
    logic                 found_next;
    logic [IDX_W-1:0]     pick_reg;
    logic [IDX_W-1:0]     pick_next;
    logic [SIZE_BITS-1:0] left_reg;
    logic [SIZE_BITS-1:0] left_next;
    logic [SIZE_BITS-1:0] before_reg;
    logic [SIZE_BITS-1:0] before_next;
    logic [SIZE_BITS:0]   diff;
    logic                 fits;
    logic                 take;

    always_comb
    begin
        diff = {1'b0, size_in} - {1'b0, req};
        fits = !diff[SIZE_BITS];
        take = 1'b0;
        if (fits)
        begin
            if (!found_reg)
            begin
                take = 1'b1;
            end
            else if (ctrl.mode == FIT_BEST)
            begin
                take = diff[SIZE_BITS-1:0] < left_reg;
            end
            else if (ctrl.mode == FIT_WORST)
            begin
                take = diff[SIZE_BITS-1:0] > left_reg;
            end
        end

        found_next = found_reg;
        pick_next = pick_reg;
        left_next = left_reg;
        before_next = before_reg;
        if (ctrl.clear)
        begin
            found_next = 1'b0;
        end
        else if (ctrl.step && take)
        begin
            found_next = 1'b1;
            pick_next = idx_in;
            left_next = diff[SIZE_BITS-1:0];
            before_next = size_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= 1'b0;
        end
        else
        begin
            found_reg <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pick_reg <= pick_next;
        left_reg <= left_next;
        before_reg <= before_next;
    end

    assign found = found_reg;
    assign pick = pick_reg;
    assign pick_left = left_reg;
    assign pick_before = before_reg;

endmodule

FILE: design/partition_fit_allocator_core.sv
// Top level of the partition fit allocator: sequencer, size tables and port logic.
// Depends on pfa_pkg, pfa_mem and pfa_fit_unit.
//
// After reset the block zeroes both size tables and accepts no beat
// meanwhile. A load writes the size into both tables if the index is in
// range. An allocation reads one partition per cycle from the remaining-size
// table through the shared compare unit, up to the clamped block count. A
// restore copies the whole original table into the remaining-size table one
// entry per cycle. One item is in work at a time; the output register lets the
// next item start while a result waits to be taken.
module partition_fit_allocator_core
    import pfa_pkg::*;
#(
    parameter int NUM_BLOCKS = 64,
    parameter int SIZE_BITS = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write_en,
    input  logic                  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [1:0]            command,
    input  logic [5:0]            block_index,
    input  logic [SIZE_BITS-1:0]  size_value,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [1:0]            status,
    output logic [OUT_IDX_W-1:0]  chosen_block,
    output logic [SIZE_BITS-1:0]  size_before,
    output logic [SIZE_BITS-1:0]  size_after
);

    localparam int IDX_W = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
    localparam int CNT_W = $clog2(NUM_BLOCKS + 1);

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_SCAN  = 6'b000100,
        S_WRITE = 6'b001000,
        S_COPY  = 6'b010000,
        S_DONE  = 6'b100000
    } pfa_state_t;

    pfa_state_t           state_reg;
    pfa_state_t           state_next;
    logic [CNT_W-1:0]     cnt_reg;
    logic [CNT_W-1:0]     cnt_next;
    logic                 rd_vld_reg;
    logic                 rd_vld_next;
    logic [IDX_W-1:0]     rd_idx_reg;
    logic [IDX_W-1:0]     rd_idx_next;
    logic [SIZE_BITS-1:0] req_reg;
    logic [SIZE_BITS-1:0] req_next;
    logic [1:0]           res_status_reg;
    logic [1:0]           res_status_next;
    logic [1:0]           fit_mode_reg;
    logic [6:0]           block_count_reg;

    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic [1:0]           status_reg;
    logic [1:0]           status_next;
    logic [OUT_IDX_W-1:0] chosen_reg;
    logic [OUT_IDX_W-1:0] chosen_next;
    logic [SIZE_BITS-1:0] before_reg;
    logic [SIZE_BITS-1:0] before_next;
    logic [SIZE_BITS-1:0] after_reg;
    logic [SIZE_BITS-1:0] after_next;

    logic                 accept;
    logic                 issue;
    logic [IDX_W-1:0]     cnt_idx;
    logic [IDX_W-1:0]     load_addr;
    logic                 load_ok;

    logic                 orig_we;
    logic [IDX_W-1:0]     orig_waddr;
    logic [SIZE_BITS-1:0] orig_wdata;
    logic [SIZE_BITS-1:0] orig_rdata;
    logic                 rem_we;
    logic [IDX_W-1:0]     rem_waddr;
    logic [SIZE_BITS-1:0] rem_wdata;
    logic [SIZE_BITS-1:0] rem_rdata;

    pfa_fit_ctrl_t        fit_ctrl;
    logic                 fit_found;
    logic [IDX_W-1:0]     fit_pick;
    logic [SIZE_BITS-1:0] fit_left;
    logic [SIZE_BITS-1:0] fit_before;

    assign in_ready = (state_reg == S_IDLE);
    assign accept = in_valid && in_ready;
    assign cnt_idx = cnt_reg[IDX_W-1:0];
    assign load_addr = IDX_W'(32'(block_index));
    assign load_ok = 32'(block_index) < NUM_BLOCKS;

    pfa_mem #(
        .DEPTH (NUM_BLOCKS),
        .WIDTH (SIZE_BITS),
        .AW    (IDX_W)
    ) u_orig_mem (
        .clk   (clk),
        .we    (orig_we),
        .waddr (orig_waddr),
        .wdata (orig_wdata),
        .raddr (cnt_idx),
        .rdata (orig_rdata)
    );

    pfa_mem #(
        .DEPTH (NUM_BLOCKS),
        .WIDTH (SIZE_BITS),
        .AW    (IDX_W)
    ) u_rem_mem (
        .clk   (clk),
        .we    (rem_we),
        .waddr (rem_waddr),
        .wdata (rem_wdata),
        .raddr (cnt_idx),
        .rdata (rem_rdata)
    );

    pfa_fit_unit #(
        .SIZE_BITS (SIZE_BITS),
        .IDX_W     (IDX_W)
    ) u_fit_unit (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (fit_ctrl),
        .size_in     (rem_rdata),
        .req         (req_reg),
        .idx_in      (rd_idx_reg),
        .found       (fit_found),
        .pick        (fit_pick),
        .pick_left   (fit_left),
        .pick_before (fit_before)
    );

    always_comb
    begin
        state_next = state_reg;
        cnt_next = cnt_reg;
        rd_vld_next = 1'b0;
        rd_idx_next = cnt_idx;
        req_next = req_reg;
        res_status_next = res_status_reg;
        issue = 1'b0;

        orig_we = 1'b0;
        orig_waddr = cnt_idx;
        orig_wdata = '0;
        rem_we = 1'b0;
        rem_waddr = cnt_idx;
        rem_wdata = '0;

        fit_ctrl.clear = 1'b0;
        fit_ctrl.step = 1'b0;
        fit_ctrl.mode = fit_mode_reg;

        out_valid_next = out_valid_reg && !out_ready;
        status_next = status_reg;
        chosen_next = chosen_reg;
        before_next = before_reg;
        after_next = after_reg;

        case (state_reg)
            S_CLEAR:
            begin
                orig_we = 1'b1;
                rem_we = 1'b1;
                cnt_next = cnt_reg + CNT_W'(1);
                if (32'(cnt_reg) == NUM_BLOCKS - 1)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                cnt_next = '0;
                if (accept)
                begin
                    case (command)
                        CMD_LOAD:
                        begin
                            orig_we = load_ok;
                            rem_we = load_ok;
                            orig_waddr = load_addr;
                            rem_waddr = load_addr;
                            orig_wdata = size_value;
                            rem_wdata = size_value;
                            res_status_next = ST_LOADED;
                            state_next = S_DONE;
                        end
                        CMD_ALLOC:
                        begin
                            fit_ctrl.clear = 1'b1;
                            req_next = size_value;
                            state_next = S_SCAN;
                        end
                        default:
                        begin
                            state_next = S_COPY;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                issue = (32'(cnt_reg) < 32'(block_count_reg)) && (32'(cnt_reg) < NUM_BLOCKS);
                fit_ctrl.step = rd_vld_reg;
                if (issue)
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
                rd_vld_next = issue;
                if (!issue && !rd_vld_reg)
                begin
                    if (fit_found)
                    begin
                        state_next = S_WRITE;
                    end
                    else
                    begin
                        res_status_next = ST_NO_SPACE;
                        state_next = S_DONE;
                    end
                end
            end
            S_WRITE:
            begin
                rem_we = 1'b1;
                rem_waddr = fit_pick;
                rem_wdata = fit_left;
                res_status_next = ST_ALLOCATED;
                state_next = S_DONE;
            end
            S_COPY:
            begin
                issue = 32'(cnt_reg) < NUM_BLOCKS;
                if (issue)
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
                rd_vld_next = issue;
                rem_we = rd_vld_reg;
                rem_waddr = rd_idx_reg;
                rem_wdata = orig_rdata;
                if (!issue && !rd_vld_reg)
                begin
                    res_status_next = ST_RESTORED;
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    status_next = res_status_reg;
                    if (res_status_reg == ST_ALLOCATED)
                    begin
                        chosen_next = OUT_IDX_W'(fit_pick);
                        before_next = fit_before;
                        after_next = fit_left;
                    end
                    else
                    begin
                        chosen_next = '0;
                        before_next = '0;
                        after_next = '0;
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            cnt_reg <= '0;
            rd_vld_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            fit_mode_reg <= FIT_FIRST;
            block_count_reg <= BLOCK_COUNT_RESET;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
            rd_vld_reg <= rd_vld_next;
            out_valid_reg <= out_valid_next;
            if (cfg_write_en && cfg_index == REG_FIT_MODE)
            begin
                fit_mode_reg <= cfg_data[1:0];
            end
            if (cfg_write_en && cfg_index == REG_BLOCK_COUNT)
            begin
                block_count_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rd_idx_reg <= rd_idx_next;
        req_reg <= req_next;
        res_status_reg <= res_status_next;
        status_reg <= status_next;
        chosen_reg <= chosen_next;
        before_reg <= before_next;
        after_reg <= after_next;
    end

    assign out_valid = out_valid_reg;
    assign status = status_reg;
    assign chosen_block = chosen_reg;
    assign size_before = before_reg;
    assign size_after = after_reg;

    // An allocation never grows a partition.
    a_alloc_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == ST_ALLOCATED) |-> (size_after <= size_before))
        else $error("allocated partition grew");

    // Results other than an allocation carry zero fields.
    a_other_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status != ST_ALLOCATED) |->
        (chosen_block == '0 && size_before == '0 && size_after == '0))
        else $error("non-allocation result carries data");

    // No table read is in flight while the block takes a new beat.
    a_idle_no_read: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !rd_vld_reg)
        else $error("table read in flight while idle");

endmodule
